// File: rtl/core/ezsl_pkg.sv
// shared types, codes and helper functions of the ellipse zone speed limiter
`timescale 1ns / 1ps

package ezsl_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  // register indexes of the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_INNER_MAJOR = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_INNER_MINOR = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_OUTER_MAJOR = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_OUTER_MINOR = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SCALE_RECIP = 3'd4;

  // register reset values
  localparam logic [31:0] RST_INNER_MAJOR = 32'd26844;
  localparam logic [31:0] RST_INNER_MINOR = 32'd68719;
  localparam logic [31:0] RST_OUTER_MAJOR = 32'd8765;
  localparam logic [31:0] RST_OUTER_MINOR = 32'd47722;
  localparam logic [31:0] RST_SCALE_RECIP = 32'd31775;

  localparam logic [16:0] ONE_Q16     = 17'd65536;
  localparam logic [46:0] LEAST_MAX   = {47{1'b1}};
  localparam logic [15:0] CREEP_VX    = 16'd100;
  localparam logic [15:0] CREEP_WZ    = 16'd200;
  localparam logic [63:0] OUTER_LIMIT = 64'h0000_0001_0000_0000;

  localparam logic KIND_POINT = 1'b0;
  localparam logic KIND_VEL   = 1'b1;

  typedef struct packed {
    logic              kind;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic              last_point;
    logic signed [15:0] cmd_vx;
    logic signed [15:0] cmd_vy;
    logic signed [15:0] cmd_wz;
  } in_item_t;

  typedef struct packed {
    logic              result_kind;
    logic              slow_zone;
    logic              stop_zone;
    logic [16:0]       speed_factor;
    logic signed [15:0] out_vx;
    logic signed [15:0] out_vy;
    logic signed [15:0] out_wz;
  } out_item_t;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SQUARE,
    OP_OUTER,
    OP_INNER,
    OP_ACCUM,
    OP_FACTOR,
    OP_EMIT_SCAN,
    OP_VEL_XY,
    OP_VEL_Z,
    OP_EMIT_VEL
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic last_point;
    logic out_free;
  } dp_status_t;

  // magnitude of a 16 bit signed value, -32768 gives 32768
  function automatic logic [15:0] abs_mag(input logic signed [15:0] v);
    abs_mag = v[15] ? (~v + 16'd1) : v;
  endfunction

  // sign restore of a scaled magnitude, with saturation of positive results only
  function automatic logic [15:0] sat_scale(input logic neg, input logic [16:0] mag);
    logic [16:0] r;
    r = mag;
    if (neg) begin
      sat_scale = 16'(~r + 17'd1);
    end else if (r > 17'd32767) begin
      sat_scale = 16'h7FFF;
    end else begin
      sat_scale = r[15:0];
    end
  endfunction

endpackage

// File: rtl/core/ellipse_zone_speed_limiter.sv
// top level of the ellipse zone speed limiter: controller plus datapath
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_ready    in_data   (ezsl_pkg::in_item_t)
//   out_     output     out_valid / out_ready  out_data  (ezsl_pkg::out_item_t)
//   cfg_     input      cfg_valid / cfg_ready  cfg_index, cfg_data (always ready)
//
// one item at a time, sequenced through the shared multiplier pair: a point runs
// squares, outer weights, inner weights and accumulate before the next in_ready,
// a last point adds factor and emit; velocity runs xy scale, z scale and emit
// a result waits in the output register; the block takes the next item meanwhile
// and stalls only when it must load a new result while the old one is untaken
// synchronous active-low reset restores register defaults, full speed factor,
// empty scan accumulators and zero idle count
`timescale 1ns / 1ps

module ellipse_zone_speed_limiter (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  ezsl_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output ezsl_pkg::out_item_t               out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ezsl_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [ezsl_pkg::CFG_DATA_W-1:0]   cfg_data
);

  ezsl_pkg::dp_cmd_t    cmd;
  ezsl_pkg::dp_status_t status;

  // register writes are taken in any cycle
  assign cfg_ready = 1'b1;

  // sequencing of the shared multipliers and the output load
  ezsl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_data.kind),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // arithmetic, scan state and output register
  ezsl_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: rtl/core/ezsl_ctrl.sv
// controller state machine sequencing points and velocity commands
`timescale 1ns / 1ps

module ezsl_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_kind,
  output logic                  in_ready,
  input  ezsl_pkg::dp_status_t  status,
  output ezsl_pkg::dp_cmd_t     cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQUARE,
    S_OUTER,
    S_INNER,
    S_ACCUM,
    S_FACTOR,
    S_EMIT_SCAN,
    S_VEL_XY,
    S_VEL_Z,
    S_EMIT_VEL
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd.op    = ezsl_pkg::OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = ezsl_pkg::OP_LOAD;
          state_nxt = (in_kind == ezsl_pkg::KIND_VEL) ? S_VEL_XY : S_SQUARE;
        end
      end
      S_SQUARE: begin
        cmd.op    = ezsl_pkg::OP_SQUARE;
        state_nxt = S_OUTER;
      end
      S_OUTER: begin
        cmd.op    = ezsl_pkg::OP_OUTER;
        state_nxt = S_INNER;
      end
      S_INNER: begin
        cmd.op    = ezsl_pkg::OP_INNER;
        state_nxt = S_ACCUM;
      end
      S_ACCUM: begin
        cmd.op    = ezsl_pkg::OP_ACCUM;
        state_nxt = status.last_point ? S_FACTOR : S_IDLE;
      end
      S_FACTOR: begin
        cmd.op    = ezsl_pkg::OP_FACTOR;
        state_nxt = S_EMIT_SCAN;
      end
      S_EMIT_SCAN: begin
        if (status.out_free) begin
          cmd.op    = ezsl_pkg::OP_EMIT_SCAN;
          state_nxt = S_IDLE;
        end
      end
      S_VEL_XY: begin
        cmd.op    = ezsl_pkg::OP_VEL_XY;
        state_nxt = S_VEL_Z;
      end
      S_VEL_Z: begin
        cmd.op    = ezsl_pkg::OP_VEL_Z;
        state_nxt = S_EMIT_VEL;
      end
      S_EMIT_VEL: begin
        if (status.out_free) begin
          cmd.op    = ezsl_pkg::OP_EMIT_VEL;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/core/ezsl_dp.sv
// datapath: registers, shared multiplier pair, scan accumulators, output register
`timescale 1ns / 1ps

module ezsl_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  ezsl_pkg::dp_cmd_t                     cmd,
  output ezsl_pkg::dp_status_t                  status,
  input  ezsl_pkg::in_item_t                    in_data,
  input  logic                                  cfg_valid,
  input  logic [ezsl_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [ezsl_pkg::CFG_DATA_W-1:0]       cfg_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output ezsl_pkg::out_item_t                   out_data
);

  // configuration registers
  logic [31:0] inner_major_r, inner_minor_r, outer_major_r, outer_minor_r, scale_recip_r;

  // working registers
  ezsl_pkg::in_item_t  item_r;
  logic [31:0]         sq_x_r, sq_y_r;
  logic [63:0]         prod0_r, prod1_r;
  logic                outer_in_r;
  logic [15:0]         vx_s_r, vy_s_r;

  // scan and command state
  logic [46:0]         least_r;
  logic                slow_r, stop_r;
  logic [16:0]         factor_r;
  logic [1:0]          idle_cnt_r;

  ezsl_pkg::out_item_t out_r;
  logic                out_valid_r;

  // multiplier operands
  logic [31:0] m0_p, m0_q, m1_p, m1_q;
  logic [63:0] prod0, prod1;
  logic [63:0] sum;
  logic [47:0] sum_q16;
  logic [46:0] e1;
  logic        e1_stop;
  logic [31:0] least_clamp;
  logic [47:0] fact_raw;
  logic [16:0] fact_cap, scan_factor;
  logic        cmd_zero;
  logic [1:0]  idle_cnt_nxt;
  logic [15:0] wz_s;

  assign status.last_point = item_r.last_point;
  assign status.out_free   = !out_valid_r || out_ready;
  assign out_valid         = out_valid_r;
  assign out_data          = out_r;

  assign least_clamp = (least_r[46:32] != 15'd0) ? 32'hFFFF_FFFF : least_r[31:0];

  always_comb begin
    m0_p = '0;
    m0_q = '0;
    m1_p = '0;
    m1_q = '0;
    unique case (cmd.op)
      ezsl_pkg::OP_SQUARE: begin
        m0_p = {16'd0, ezsl_pkg::abs_mag(item_r.point_x)};
        m0_q = m0_p;
        m1_p = {16'd0, ezsl_pkg::abs_mag(item_r.point_y)};
        m1_q = m1_p;
      end
      ezsl_pkg::OP_OUTER: begin
        m0_p = sq_x_r;
        m0_q = outer_major_r;
        m1_p = sq_y_r;
        m1_q = outer_minor_r;
      end
      ezsl_pkg::OP_INNER: begin
        m0_p = sq_x_r;
        m0_q = inner_major_r;
        m1_p = sq_y_r;
        m1_q = inner_minor_r;
      end
      ezsl_pkg::OP_FACTOR: begin
        m0_p = least_clamp;
        m0_q = scale_recip_r;
      end
      ezsl_pkg::OP_VEL_XY: begin
        m0_p = {16'd0, ezsl_pkg::abs_mag(item_r.cmd_vx)};
        m0_q = {15'd0, factor_r};
        m1_p = {16'd0, ezsl_pkg::abs_mag(item_r.cmd_vy)};
        m1_q = {15'd0, factor_r};
      end
      ezsl_pkg::OP_VEL_Z: begin
        m0_p = {16'd0, ezsl_pkg::abs_mag(item_r.cmd_wz)};
        m0_q = {15'd0, factor_r};
      end
      default: begin
      end
    endcase
  end

  assign prod0 = m0_p * m0_q;
  assign prod1 = m1_p * m1_q;

  // sum of the two weighted squares, never above 2^63
  assign sum     = prod0_r + prod1_r;
  assign sum_q16 = sum[63:16];
  assign e1_stop = (sum_q16 <= 48'd65536);
  assign e1      = e1_stop ? 47'd0 : 47'(sum_q16 - 48'd65536);

  // scan factor from the least inner value
  assign fact_raw    = prod0_r[63:16];
  assign fact_cap    = (fact_raw > 48'd65536) ? ezsl_pkg::ONE_Q16 : fact_raw[16:0];
  assign scan_factor = stop_r ? 17'd0 : (!slow_r ? ezsl_pkg::ONE_Q16 : fact_cap);

  // idle command handling
  assign cmd_zero     = (item_r.cmd_vx == 16'sd0) && (item_r.cmd_vy == 16'sd0) &&
                        (item_r.cmd_wz == 16'sd0);
  assign idle_cnt_nxt = !cmd_zero ? 2'd0 : ((idle_cnt_r == 2'd3) ? 2'd3 : idle_cnt_r + 2'd1);
  assign wz_s         = ezsl_pkg::sat_scale(item_r.cmd_wz[15], prod0_r[32:16]);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inner_major_r <= ezsl_pkg::RST_INNER_MAJOR;
      inner_minor_r <= ezsl_pkg::RST_INNER_MINOR;
      outer_major_r <= ezsl_pkg::RST_OUTER_MAJOR;
      outer_minor_r <= ezsl_pkg::RST_OUTER_MINOR;
      scale_recip_r <= ezsl_pkg::RST_SCALE_RECIP;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ezsl_pkg::REG_INNER_MAJOR: inner_major_r <= cfg_data;
        ezsl_pkg::REG_INNER_MINOR: inner_minor_r <= cfg_data;
        ezsl_pkg::REG_OUTER_MAJOR: outer_major_r <= cfg_data;
        ezsl_pkg::REG_OUTER_MINOR: outer_minor_r <= cfg_data;
        ezsl_pkg::REG_SCALE_RECIP: scale_recip_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // payload and product registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      ezsl_pkg::OP_LOAD: item_r <= in_data;
      ezsl_pkg::OP_SQUARE: begin
        sq_x_r <= prod0[31:0];
        sq_y_r <= prod1[31:0];
      end
      ezsl_pkg::OP_OUTER: begin
        prod0_r <= prod0;
        prod1_r <= prod1;
      end
      ezsl_pkg::OP_INNER: begin
        outer_in_r <= (sum <= ezsl_pkg::OUTER_LIMIT);
        prod0_r    <= prod0;
        prod1_r    <= prod1;
      end
      ezsl_pkg::OP_FACTOR: prod0_r <= prod0;
      ezsl_pkg::OP_VEL_XY: begin
        prod0_r <= prod0;
        prod1_r <= prod1;
      end
      ezsl_pkg::OP_VEL_Z: begin
        vx_s_r  <= ezsl_pkg::sat_scale(item_r.cmd_vx[15], prod0_r[32:16]);
        vy_s_r  <= ezsl_pkg::sat_scale(item_r.cmd_vy[15], prod1_r[32:16]);
        prod0_r <= prod0;
      end
      default: begin
      end
    endcase
  end

  // scan accumulators, factor in use and idle count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      least_r    <= ezsl_pkg::LEAST_MAX;
      slow_r     <= 1'b0;
      stop_r     <= 1'b0;
      factor_r   <= ezsl_pkg::ONE_Q16;
      idle_cnt_r <= 2'd0;
    end else begin
      unique case (cmd.op)
        ezsl_pkg::OP_ACCUM: begin
          if (outer_in_r) begin
            slow_r <= 1'b1;
            if (e1_stop) begin
              stop_r <= 1'b1;
            end
            if (e1 < least_r) begin
              least_r <= e1;
            end
          end
        end
        ezsl_pkg::OP_EMIT_SCAN: begin
          factor_r <= scan_factor;
          least_r  <= ezsl_pkg::LEAST_MAX;
          slow_r   <= 1'b0;
          stop_r   <= 1'b0;
        end
        ezsl_pkg::OP_EMIT_VEL: idle_cnt_r <= idle_cnt_nxt;
        default: begin
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == ezsl_pkg::OP_EMIT_SCAN || cmd.op == ezsl_pkg::OP_EMIT_VEL) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == ezsl_pkg::OP_EMIT_SCAN) begin
      out_r.result_kind  <= ezsl_pkg::KIND_POINT;
      out_r.slow_zone    <= slow_r;
      out_r.stop_zone    <= stop_r;
      out_r.speed_factor <= scan_factor;
      out_r.out_vx       <= '0;
      out_r.out_vy       <= '0;
      out_r.out_wz       <= '0;
    end else if (cmd.op == ezsl_pkg::OP_EMIT_VEL) begin
      out_r.result_kind  <= ezsl_pkg::KIND_VEL;
      out_r.slow_zone    <= 1'b0;
      out_r.stop_zone    <= 1'b0;
      out_r.speed_factor <= factor_r;
      if (idle_cnt_nxt > 2'd1) begin
        out_r.out_vx <= ezsl_pkg::CREEP_VX;
        out_r.out_vy <= '0;
        out_r.out_wz <= ezsl_pkg::CREEP_WZ;
      end else begin
        out_r.out_vx <= vx_s_r;
        out_r.out_vy <= vy_s_r;
        out_r.out_wz <= wz_s;
      end
    end
  end

endmodule
